### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### design/socnt_pkg.sv
// Types and constants of the satellite observation count table.
package socnt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KIND_COUNT  = 5;

  localparam int CONS_W   = 3;
  localparam int SAT_W    = 8;
  localparam int KIND_W   = 3;
  localparam int KEY_W    = CONS_W + SAT_W;
  localparam int COUNT_W  = 17;
  localparam int STATUS_W = 3;
  localparam int TOT_W    = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'd99999;

  typedef enum logic [STATUS_W-1:0] {
    ST_INCREMENTED = 3'd0,
    ST_ADDED       = 3'd1,
    ST_FULL        = 3'd2,
    ST_ZERO_SAT    = 3'd3,
    ST_BAD_KIND    = 3'd4
  } status_e;

  typedef struct packed {
    logic                vld;
    logic                done;
    logic [CONS_W-1:0]   cons;
    logic [SAT_W-1:0]    sat;
    logic [KIND_W-1:0]   kind;
    status_e             status;
    logic [COUNT_W-1:0]  count;
    logic [TOT_W-1:0]    cons_cnt;
    logic [TOT_W-1:0]    tot_cnt;
  } tok_t;

endpackage

### design/socnt_cell.sv
// One table slot: key, kind counters and the item token register.
module socnt_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  socnt_pkg::tok_t  tok_i,
  output socnt_pkg::tok_t  tok_o
);

  logic                                valid_q, valid_d;
  logic [socnt_pkg::KEY_W-1:0]         key_q, key_d;
  logic [socnt_pkg::COUNT_W-1:0]       cnt_q [socnt_pkg::KIND_COUNT];
  logic [socnt_pkg::COUNT_W-1:0]       cnt_d [socnt_pkg::KIND_COUNT];
  logic [socnt_pkg::COUNT_W-1:0]       inc   [socnt_pkg::KIND_COUNT];
  logic [socnt_pkg::KIND_COUNT-1:0]    sel;
  socnt_pkg::tok_t                     tok_q, tok_d;
  logic                                active, hit, take, cons_match;

  always_comb begin
    active  = tok_i.vld && !tok_i.done;
    hit     = active && valid_q && (key_q == {tok_i.cons, tok_i.sat});
    take    = active && !valid_q;
    valid_d = valid_q || take;
    key_d   = take ? {tok_i.cons, tok_i.sat} : key_q;
    tok_d   = tok_i;
    for (int k = 0; k < socnt_pkg::KIND_COUNT; k++) begin
      sel[k] = (tok_i.kind == socnt_pkg::KIND_W'(k));
      inc[k] = (cnt_q[k] < socnt_pkg::COUNT_MAX) ? cnt_q[k] + 1'b1 : socnt_pkg::COUNT_MAX;
      cnt_d[k] = cnt_q[k];
      if (hit && sel[k]) begin
        cnt_d[k]    = inc[k];
        tok_d.count = inc[k];
      end
      if (take) begin
        cnt_d[k] = sel[k] ? socnt_pkg::COUNT_W'(1) : '0;
      end
    end
    if (hit) begin
      tok_d.done   = 1'b1;
      tok_d.status = socnt_pkg::ST_INCREMENTED;
    end
    if (take) begin
      tok_d.done   = 1'b1;
      tok_d.status = socnt_pkg::ST_ADDED;
      tok_d.count  = socnt_pkg::COUNT_W'(1);
    end
    cons_match     = valid_d && (key_d[socnt_pkg::KEY_W-1:socnt_pkg::SAT_W] == tok_i.cons);
    tok_d.cons_cnt = tok_i.cons_cnt + socnt_pkg::TOT_W'(cons_match);
    tok_d.tot_cnt  = tok_i.tot_cnt + socnt_pkg::TOT_W'(valid_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else if (adv_i) begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      key_q <= key_d;
      for (int k = 0; k < socnt_pkg::KIND_COUNT; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
    end
  end

  assign tok_o = tok_q;

endmodule

### design/satellite_observation_count_table_top.sv
// Top level of the satellite observation count table: entry, cell chain and output register.
//
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    constellation, satellite_number, kind
// out      output     out_valid_o / out_ready_i  count_after, status, sats_in_constellation,
//                                                sats_total
//
// An item walks the row of TABLE_DEPTH slot cells, one cell per cycle unless the row is held,
// and one item is in the row at a time: the next item is accepted once the last has left
// the row. Reset empties every slot at once; a taken slot zeroes its kind counters but
// sets the item's to one. A result waiting in the output register holds the whole row.
module satellite_observation_count_table_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [socnt_pkg::CONS_W-1:0]     constellation_i,
  input  logic [socnt_pkg::SAT_W-1:0]      satellite_number_i,
  input  logic [socnt_pkg::KIND_W-1:0]     observation_kind_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [socnt_pkg::COUNT_W-1:0]    count_after_o,
  output logic [socnt_pkg::STATUS_W-1:0]   status_o,
  output logic [socnt_pkg::TOT_W-1:0]      sats_in_constellation_o,
  output logic [socnt_pkg::TOT_W-1:0]      sats_total_o
);

  `include "assert_macros.svh"

  socnt_pkg::tok_t                        chain [socnt_pkg::TABLE_DEPTH+1];
  logic [socnt_pkg::TABLE_DEPTH-1:0]      tok_vld;
  socnt_pkg::tok_t                        entry;
  socnt_pkg::tok_t                        out_q, out_d;
  logic                                   out_valid_q, out_valid_d;
  logic                                   busy_q, busy_d;
  logic                                   adv, accept;
  socnt_pkg::tok_t                        last;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !busy_q && adv;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    entry          = '0;
    entry.vld      = accept;
    entry.cons     = constellation_i;
    entry.sat      = satellite_number_i;
    entry.kind     = observation_kind_i;
    entry.status   = socnt_pkg::ST_FULL;
    if (4'(observation_kind_i) >= 4'(socnt_pkg::KIND_COUNT)) begin
      entry.done   = 1'b1;
      entry.status = socnt_pkg::ST_BAD_KIND;
    end else if (satellite_number_i == '0) begin
      entry.done   = 1'b1;
      entry.status = socnt_pkg::ST_ZERO_SAT;
    end
  end

  assign chain[0] = entry;

  for (genvar i = 0; i < socnt_pkg::TABLE_DEPTH; i++) begin : g_cell
    socnt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (chain[i]),
      .tok_o  (chain[i+1])
    );
    assign tok_vld[i] = chain[i+1].vld;
  end

  assign last = chain[socnt_pkg::TABLE_DEPTH];

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (adv && last.vld) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      out_d       = last;
      if (!last.done) begin
        out_d.status = socnt_pkg::ST_FULL;
        out_d.count  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o             = out_valid_q;
  assign count_after_o           = out_q.count;
  assign status_o                = out_q.status;
  assign sats_in_constellation_o = out_q.cons_cnt;
  assign sats_total_o            = out_q.tot_cnt;

  `ASSERT_RST(a_accept_sets_busy, accept |=> busy_q)
  `ASSERT_RST(a_one_item_in_row, $onehot0(tok_vld))
  `ASSERT_RST(a_result_from_row, $rose(out_valid_q) |-> $past(last.vld))
  `ASSERT_RST(a_added_count_one,
    out_valid_q && (out_q.status == socnt_pkg::ST_ADDED) |-> (out_q.count == 17'd1))

endmodule
